// ===== design/spr_pkg.sv =====
package spr_pkg;

	localparam int PWR_W      = 13;
	localparam int PIX_W      = 12;
	localparam int LVL_W      = 13;
	localparam int AVG_W      = 21;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;
	localparam int NUM_W      = 20;
	localparam int QUOT_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REAL_MODE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RATIO = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATIO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_DB    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_DB     = 3'd6;

	localparam logic [13:0] RST_BIN_COUNT    = 14'd1024;
	localparam logic        RST_REAL_MODE    = 1'b0;
	localparam logic [12:0] RST_OUTPUT_WIDTH = 13'd1024;
	localparam logic [8:0]  RST_ATTACK_RATIO = 9'd154;
	localparam logic [8:0]  RST_DECAY_RATIO  = 9'd128;
	localparam logic [7:0]  RST_OFFSET_DB    = 8'd30;
	localparam logic [7:0]  RST_RANGE_DB     = 8'd80;

	localparam logic [LVL_W-1:0] LEVEL_ONE = 13'd4096;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [7:0]        den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== design/spr_if.sv =====
interface spr_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [spr_pkg::PWR_W-1:0]  power_db;
	modport source (output valid, output power_db, input ready);
	modport sink (input valid, input power_db, output ready);
endinterface

interface spr_out_if;
	logic                              valid;
	logic                              ready;
	logic [spr_pkg::PIX_W-1:0]         pixel_index;
	logic signed [spr_pkg::PWR_W-1:0]  smoothed_db;
	logic [spr_pkg::LVL_W-1:0]         display_level;
	logic                              last_of_run;
	logic                              last_of_frame;
	modport source (output valid, output pixel_index, output smoothed_db,
		output display_level, output last_of_run, output last_of_frame, input ready);
	modport sink (input valid, input pixel_index, input smoothed_db,
		input display_level, input last_of_run, input last_of_frame, output ready);
endinterface

interface spr_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [spr_pkg::CFG_IDX_W-1:0]       index;
	logic [spr_pkg::CFG_DATA_W-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/spectrum_peak_resize_smooth.sv =====
// Spectrum peak-hold resize with attack/decay smoothing.
//
// Channels: bin_in carries one bin power in 1/16 dB per beat, bins in display
// order. pix_out carries one beat per display pixel written: pixel index,
// smoothed level, Q1.12 display level and run/frame end marks. cfg writes one
// register per beat (index 0..6); writes to bin_count, real_mode or
// output_width restart the frame. cfg is always ready; bin_in drops ready in a
// cycle that carries such a geometry write.
// Per pixel: each pixel that a bin reaches runs a read-modify-write of the
// smoothing memory (read, multiply, update), then the level step and, when
// the level is not clamped, the bit-serial level divider, then the emit step.
// No new bin is taken until every pixel of the last bin has been emitted.
// Reset: all control clears and a clearing pass writes zero to each of the
// MAX_WIDTH smoothing entries, one a cycle; bin_in stays not ready during it,
// config writes are taken.
// Stall: a finished pixel waits in the output register; the engine holds until
// the register is free, so nothing is lost under back pressure.
module spectrum_peak_resize_smooth #(
	parameter int MAX_BINS  = 8192,
	parameter int MAX_WIDTH = 4096
) (
	input logic clk,
	input logic arst_n,
	spr_in_if.sink    bin_in,
	spr_out_if.source pix_out,
	spr_cfg_if.sink   cfg
);
	import spr_pkg::*;

	localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int NB_CAP = (MAX_BINS > 16383) ? 16383 : MAX_BINS;
	localparam int WD_CAP = (MAX_WIDTH > 8191) ? 8191 : MAX_WIDTH;

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_LVL  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_EMIT = 3'd7;

	// configuration
	logic [13:0] bins_q;
	logic        real_q;
	logic [12:0] width_q;
	logic [8:0]  attack_q;
	logic [8:0]  decay_q;
	logic [7:0]  offset_q;
	logic [7:0]  range_q;

	// frame state
	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [13:0]           binpos_q;
	logic [12:0]           pixel_q;
	logic [13:0]           rem_q;
	logic signed [PWR_W-1:0] peak_q;
	logic                  restart_q;
	logic                  pend_q;

	// pixel datapath
	logic signed [AVG_W-1:0] avg_q;
	logic signed [31:0]      prod_q;
	logic [LVL_W-1:0]        level_q;

	// output register
	logic                    out_valid_q;
	logic [PIX_W-1:0]        out_pix_q;
	logic signed [PWR_W-1:0] out_db_q;
	logic [LVL_W-1:0]        out_lvl_q;
	logic                    out_lor_q;
	logic                    out_lof_q;

	// derived geometry
	logic [13:0] n_eff, skip, used;
	logic [12:0] w_cap;
	logic [19:0] w64;
	logic [12:0] w_eff;

	always_comb begin
		if (bins_q < 14'd2) begin
			n_eff = 14'd2;
		end else if (bins_q > 14'(NB_CAP)) begin
			n_eff = 14'(NB_CAP);
		end else begin
			n_eff = bins_q;
		end
		skip  = real_q ? (n_eff >> 1) : 14'd0;
		used  = real_q ? (n_eff >> 1) : n_eff;
		w_cap = (width_q == 13'd0) ? 13'd1 : width_q;
		if (w_cap > 13'(WD_CAP)) begin
			w_cap = 13'(WD_CAP);
		end
		w64   = {used, 6'b0};
		w_eff = (20'(w_cap) > w64) ? w64[12:0] : w_cap;
	end

	// bin accept decode
	logic        in_fire, cfg_fire, cfg_geom;
	logic        active, run, frame_end;
	logic [13:0] rem_new;

	assign in_fire   = bin_in.valid && bin_in.ready;
	assign cfg_fire  = cfg.valid && cfg.ready;
	assign cfg_geom  = cfg_fire && (cfg.index == REG_BIN_COUNT ||
		cfg.index == REG_REAL_MODE || cfg.index == REG_OUTPUT_WIDTH);
	assign active    = (binpos_q >= skip) && ((binpos_q - skip) < used);
	assign rem_new   = rem_q + 14'(w_eff);
	assign run       = active && (rem_new >= used);
	assign frame_end = (15'(binpos_q) + 15'd1) >= 15'(n_eff);

	// smoothing arithmetic
	logic [AVG_W-1:0]        rd_data;
	logic signed [AVG_W-1:0] xs;
	logic signed [21:0]      diff;
	logic [8:0]              ratio;
	logic signed [23:0]      inc;
	logic signed [AVG_W-1:0] avg_new;

	assign xs    = {peak_q, 8'b0};
	assign diff  = 22'(xs) - 22'($signed(rd_data));
	assign ratio = ($signed(rd_data) < xs) ? ((attack_q > 9'd256) ? 9'd256 : attack_q)
		: ((decay_q > 9'd256) ? 9'd256 : decay_q);
	assign inc     = 24'((prod_q + 32'sd128) >>> 8);
	assign avg_new = AVG_W'(24'(avg_q) + inc);

	// level: clamp((-avg - offset) / range, 0, 1)
	logic signed [22:0] num;
	logic [7:0]         rng;
	logic [19:0]        lim;
	logic signed [21:0] db_round;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign num      = -23'(avg_q) - $signed({3'b0, offset_q, 12'b0});
	assign rng      = (range_q == 8'd0) ? 8'd1 : range_q;
	assign lim      = {rng, 12'b0};
	assign db_round = 22'(avg_q) + 22'sd128;

	assign div_req.start = (state_q == ST_LVL) && (num > 23'sd0) && (num < $signed({3'b0, lim}));
	assign div_req.num   = num[19:0];
	assign div_req.den   = rng;

	spr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// memory ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AVG_W-1:0] mem_wdata;

	assign mem_we    = (state_q == ST_CLR) || (state_q == ST_UPD);
	assign mem_waddr = (state_q == ST_CLR) ? clr_q : AW'(pixel_q);
	assign mem_wdata = (state_q == ST_CLR) ? '0 : avg_new;

	spr_store #(.DEPTH(MAX_WIDTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (state_q == ST_RD),
		.raddr (AW'(pixel_q)),
		.rdata (rd_data)
	);

	logic emit_go, last_run;
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || pix_out.ready);
	assign last_run = (rem_q - used) < used;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q   <= RST_BIN_COUNT;
			real_q   <= RST_REAL_MODE;
			width_q  <= RST_OUTPUT_WIDTH;
			attack_q <= RST_ATTACK_RATIO;
			decay_q  <= RST_DECAY_RATIO;
			offset_q <= RST_OFFSET_DB;
			range_q  <= RST_RANGE_DB;
		end else if (cfg_fire) begin
			case (cfg.index)
				REG_BIN_COUNT:    bins_q   <= cfg.data;
				REG_REAL_MODE:    real_q   <= cfg.data[0];
				REG_OUTPUT_WIDTH: width_q  <= cfg.data[12:0];
				REG_ATTACK_RATIO: attack_q <= cfg.data[8:0];
				REG_DECAY_RATIO:  decay_q  <= cfg.data[8:0];
				REG_OFFSET_DB:    offset_q <= cfg.data[7:0];
				REG_RANGE_DB:     range_q  <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			binpos_q  <= '0;
			pixel_q   <= '0;
			rem_q     <= '0;
			peak_q    <= '0;
			restart_q <= 1'b1;
			pend_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_WIDTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_fire && !cfg_geom) begin
						if (active) begin
							if (restart_q || bin_in.power_db > peak_q) begin
								peak_q <= bin_in.power_db;
							end
							rem_q     <= rem_new;
							restart_q <= run;
						end
						if (run) begin
							state_q <= ST_RD;
						end
						if (frame_end) begin
							binpos_q <= '0;
							if (run) begin
								pend_q <= 1'b1;
							end else begin
								// frame ends with no run: restart now
								pixel_q   <= '0;
								rem_q     <= '0;
								peak_q    <= '0;
								restart_q <= 1'b1;
							end
						end else begin
							binpos_q <= binpos_q + 14'd1;
						end
					end
				end
				ST_RD:  state_q <= ST_MUL;
				ST_MUL: state_q <= ST_UPD;
				ST_UPD: state_q <= ST_LVL;
				ST_LVL: state_q <= div_req.start ? ST_DIV : ST_EMIT;
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						rem_q   <= rem_q - used;
						pixel_q <= pixel_q + 13'd1;
						if (last_run) begin
							state_q <= ST_IDLE;
							if (pend_q) begin
								pend_q    <= 1'b0;
								pixel_q   <= '0;
								rem_q     <= '0;
								peak_q    <= '0;
								restart_q <= 1'b1;
							end
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_geom) begin
				binpos_q  <= '0;
				pixel_q   <= '0;
				rem_q     <= '0;
				peak_q    <= '0;
				restart_q <= 1'b1;
				pend_q    <= 1'b0;
			end
		end
	end

	// pixel datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			avg_q  <= $signed(rd_data);
			prod_q <= 32'(diff) * $signed({23'b0, ratio});
		end
		if (state_q == ST_UPD) begin
			avg_q <= avg_new;
		end
		if (state_q == ST_LVL) begin
			level_q <= (num <= 23'sd0) ? '0 : LEVEL_ONE;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			level_q <= LVL_W'(div_rsp.quot);
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_pix_q <= pixel_q[PIX_W-1:0];
			out_db_q  <= db_round[20:8];
			out_lvl_q <= level_q;
			out_lor_q <= last_run;
			out_lof_q <= (pixel_q + 13'd1) == w_eff;
		end
	end

	// hold off a bin while a geometry write restarts the frame
	assign bin_in.ready          = (state_q == ST_IDLE) && !cfg_geom;
	assign cfg.ready             = 1'b1;
	assign pix_out.valid         = out_valid_q;
	assign pix_out.pixel_index   = out_pix_q;
	assign pix_out.smoothed_db   = out_db_q;
	assign pix_out.display_level = out_lvl_q;
	assign pix_out.last_of_run   = out_lor_q;
	assign pix_out.last_of_frame = out_lof_q;

	a_pixel_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> pixel_q < w_eff)
		else $error("pixel index beyond frame width");

	a_run_has_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RD |-> rem_q >= used)
		else $error("pixel read with no pixel owed");

	a_frame_end_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go && (pixel_q + 13'd1) == w_eff |-> last_run)
		else $error("frame ended inside a run");

	a_level_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_lvl_q <= LEVEL_ONE)
		else $error("display level above one");

endmodule

// ===== design/spr_store.sv =====
module spr_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [spr_pkg::AVG_W-1:0]   wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [spr_pkg::AVG_W-1:0]   rdata
);
	import spr_pkg::*;

	logic [AVG_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/spr_div.sv =====
module spr_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spr_pkg::div_req_t req,
	output spr_pkg::div_rsp_t rsp
);
	import spr_pkg::*;

	logic [NUM_W-1:0]  rem_q;
	logic [7:0]        den_q;
	logic [3:0]        cnt_q;
	logic [QUOT_W-1:0] quot_q;
	logic              busy_q;
	logic              done_q;
	logic [NUM_W-1:0]  den_sh;

	// numerator is known to be below den << QUOT_W: one quotient bit a cycle
	assign den_sh = NUM_W'(den_q) << cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(QUOT_W - 1);
			end else if (busy_q) begin
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.num;
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q && rem_q >= den_sh) begin
			rem_q         <= rem_q - den_sh;
			quot_q[cnt_q] <= 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== verif/tb_spectrum_peak_resize_smooth.sv =====
`timescale 1ns / 100ps

module tb_spectrum_peak_resize_smooth;
	import spr_pkg::*;

	// Fields of one expected pixel beat.
	typedef struct {
		logic [PIX_W-1:0] pixel_index;
		logic [PWR_W-1:0] smoothed_db;
		logic [LVL_W-1:0] display_level;
		logic             last_of_run;
		logic             last_of_frame;
	} pixel_beat_t;

	// Holds its own copy of the registers, the frame position and the
	// smoothing memory, and turns each accepted bin into expected pixel beats.
	class pixel_scoreboard;
		int unsigned bin_count, real_mode, out_width, attack, decay, offset, range_db;
		int unsigned bin_pos, pix_pos;
		int          peak;
		bit          restart;
		longint      avg_mem[4096];
		pixel_beat_t pending[$];
		pixel_beat_t head;

		function new();
			bin_count = RST_BIN_COUNT;
			real_mode = RST_REAL_MODE;
			out_width = RST_OUTPUT_WIDTH;
			attack    = RST_ATTACK_RATIO;
			decay     = RST_DECAY_RATIO;
			offset    = RST_OFFSET_DB;
			range_db  = RST_RANGE_DB;
			foreach (avg_mem[i]) avg_mem[i] = 0;
			restart_frame();
		endfunction

		function void restart_frame();
			bin_pos = 0;
			pix_pos = 0;
			peak    = 0;
			restart = 1;
		endfunction

		function longint floor_div(longint a, longint b);
			if (a >= 0)
				return a / b;
			return -((-a + b - 1) / b);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_BIN_COUNT: begin
					bin_count = data;
					restart_frame();
				end
				REG_REAL_MODE: begin
					real_mode = data[0];
					restart_frame();
				end
				REG_OUTPUT_WIDTH: begin
					out_width = data[12:0];
					restart_frame();
				end
				REG_ATTACK_RATIO: attack = data[8:0];
				REG_DECAY_RATIO:  decay = data[8:0];
				REG_OFFSET_DB:    offset = data[7:0];
				REG_RANGE_DB:     range_db = data[7:0];
				default: ;
			endcase
		endfunction

		// Note one accepted bin and queue the pixels it reaches.
		function int note_bin(logic signed [PWR_W-1:0] power);
			int unsigned n, skip, used, w, p, target, k, ra, rd;
			longint      rng, xs, avg, r, num, lvl;
			int          x, cnt;
			bit          active;
			pixel_beat_t e;
			n      = bin_count < 2 ? 2 : (bin_count > 8192 ? 8192 : bin_count);
			skip   = real_mode ? n / 2 : 0;
			used   = real_mode ? n / 2 : n;
			w      = out_width == 0 ? 1 : out_width;
			p      = bin_pos;
			x      = power;
			target = 0;
			active = 0;
			cnt    = 0;
			if (w > 4096)
				w = 4096;
			if (w > 64 * used)
				w = 64 * used;
			if (p >= skip && p - skip < used) begin
				k = p - skip + 1;
				active = 1;
				if (restart || x > peak)
					peak = x;
				target = 32'((longint'(k) * w) / used);
				restart = pix_pos < target;
			end
			if (active) begin
				ra  = attack > 256 ? 256 : attack;
				rd  = decay > 256 ? 256 : decay;
				rng = range_db == 0 ? 1 : range_db;
				xs  = longint'(peak) * 256;
				while (pix_pos < target && cnt < 64) begin
					avg = avg_mem[pix_pos % 4096];
					r   = avg < xs ? ra : rd;
					avg = floor_div(avg * (256 - r) + xs * r + 128, 256);
					avg_mem[pix_pos % 4096] = avg;
					num = -avg - longint'(offset) * 4096;
					lvl = num <= 0 ? 0 : num / rng;
					if (lvl > 4096)
						lvl = 4096;
					e.pixel_index   = pix_pos[PIX_W-1:0];
					e.smoothed_db   = PWR_W'(floor_div(avg + 128, 256));
					e.display_level = LVL_W'(lvl);
					e.last_of_run   = 0;
					e.last_of_frame = (pix_pos + 1 == w);
					pending.push_back(e);
					pix_pos++;
					cnt++;
				end
				if (cnt > 0)
					pending[pending.size()-1].last_of_run = 1;
			end
			if (p + 1 >= n)
				restart_frame();
			else
				bin_pos = p + 1;
			return cnt;
		endfunction

		// 0: match, 1: nothing pending, 2: field mismatch (head holds the expectation).
		function int check_pixel(pixel_beat_t got);
			if (pending.size() == 0)
				return 1;
			head = pending.pop_front();
			if (got.pixel_index !== head.pixel_index || got.smoothed_db !== head.smoothed_db ||
					got.display_level !== head.display_level ||
					got.last_of_run !== head.last_of_run ||
					got.last_of_frame !== head.last_of_frame)
				return 2;
			return 0;
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int NUM_PHASES     = 7;
	localparam int RANDOM_BINS    = 17;

	logic clk;
	logic arst_n;

	spr_in_if  bin_in ();
	spr_out_if pix_out ();
	spr_cfg_if cfg ();

	spectrum_peak_resize_smooth uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bin_in  (bin_in),
		.pix_out (pix_out),
		.cfg     (cfg)
	);

	pixel_scoreboard sb;
	int  mismatches;
	int  bins_sent;
	int  pixels_seen;
	int  idle_cycles;
	bit  idling_on;
	pixel_beat_t got;

	// Register settings per phase: bin_count, real_mode, output_width,
	// attack, decay, offset, range. Covers clamped bin counts, zero and
	// oversized widths, saturated ratios, zero range and odd real frames.
	int phase_regs[NUM_PHASES][7] = '{
		'{8,     0, 16,   256, 0,   0,   1},
		'{2,     0, 4096, 511, 300, 255, 0},
		'{7,     1, 10,   0,   256, 30,  80},
		'{0,     1, 3,    154, 128, 10,  255},
		'{16383, 0, 0,    100, 200, 0,   255},
		'{40,    0, 4096, 77,  33,  5,   1},
		'{12,    1, 8191, 200, 50,  100, 7}
	};

	// Directed bins: the ends -3200 and 3199 of the test range, sign boundary and small steps.
	int directed_power[16] = '{-3200, 3199, 0, -1, 1, -16, 16, -3200,
		3199, 3199, -2048, 2047, -1600, 800, -3200, 0};

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report(input string what);
		mismatches++;
		$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Sample every channel at the rising edge. Note the bin before checking
	// pixels; a bin never yields a pixel beat in its own cycle.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				sb.write_reg(cfg.index, cfg.data);
			if (bin_in.valid && bin_in.ready) begin
				void'(sb.note_bin(bin_in.power_db));
				bins_sent++;
			end
			if (pix_out.valid && pix_out.ready) begin
				pixels_seen++;
				got.pixel_index   = pix_out.pixel_index;
				got.smoothed_db   = pix_out.smoothed_db;
				got.display_level = pix_out.display_level;
				got.last_of_run   = pix_out.last_of_run;
				got.last_of_frame = pix_out.last_of_frame;
				case (sb.check_pixel(got))
					1: report($sformatf("pixel %0d beat with nothing expected",
						got.pixel_index));
					2: report($sformatf({"pixel got %0d/%0d/%0d/%0b/%0b ",
						"want %0d/%0d/%0d/%0b/%0b"},
						got.pixel_index, $signed(got.smoothed_db), got.display_level,
						got.last_of_run, got.last_of_frame, sb.head.pixel_index,
						$signed(sb.head.smoothed_db), sb.head.display_level,
						sb.head.last_of_run, sb.head.last_of_frame));
					default: ;
				endcase
			end
		end
	end

	// Count cycles without any beat; a clearing pass after reset fits well inside.
	always @(posedge clk) begin
		if (!arst_n || (cfg.valid && cfg.ready) || (bin_in.valid && bin_in.ready) ||
				(pix_out.valid && pix_out.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Back pressure on the pixel side: random stall bursts of random length while idling is on.
	initial begin : pixel_ready_gen
		int hold;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				hold = $urandom_range(1, 7);
				pix_out.ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
			pix_out.ready = 1'b1;
		end
	end

	task automatic send_bin(input int power);
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			bin_in.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		bin_in.valid    = 1'b1;
		bin_in.power_db = PWR_W'(power);
		do @(posedge clk); while (!bin_in.ready);
		// Drop valid at the next falling edge.
		@(negedge clk);
		bin_in.valid = 1'b0;
	endtask

	// Hold until every expected pixel has come, then let the engine drain.
	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = CFG_DATA_W'(value);
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	task automatic load_phase(input int ph);
		drain();
		for (int i = 0; i < 7; i++)
			write_reg(CFG_IDX_W'(i), phase_regs[ph][i]);
	endtask

	// Random bins: mostly uniform over -3200..3199, sometimes one of the two
	// ends of that range.
	function automatic int random_power();
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 1) ? 3199 : -3200;
		return int'($urandom_range(0, 6399)) - 3200;
	endfunction

	initial begin
		sb          = new();
		mismatches  = 0;
		bins_sent   = 0;
		pixels_seen = 0;
		idling_on   = 1'b1;
		arst_n      = 1'b0;
		bin_in.valid    = 1'b0;
		bin_in.power_db = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed part on a tiny frame: two pixels per bin, full attack, no decay.
		load_phase(0);
		foreach (directed_power[i])
			send_bin(directed_power[i]);

		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			load_phase(ph);
			// An index past the register list must change nothing.
			if (ph == 2)
				write_reg(3'd7, 16'h3fff);
			// Turn idling off for the last phase.
			if (ph == NUM_PHASES - 1)
				idling_on = 1'b0;
			for (int i = 0; i < RANDOM_BINS; i++) begin
				// Pause the sender once until the pixel side has caught up.
				if (ph == 3 && i == 8)
					while (sb.pending.size() != 0) @(negedge clk);
				send_bin(random_power());
			end
		end

		drain();
		$display("covered %0d bins over %0d register settings, %0d pixel beats checked",
			bins_sent, NUM_PHASES, pixels_seen);
		if (mismatches == 0 && sb.pending.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
